[design/lflt_pkg.sv]
package lflt_pkg;

    // One timer tick with the five sensor levels.
    typedef struct packed {
        logic left_upper_sensor;
        logic right_upper_sensor;
        logic left_lower_sensor;
        logic right_lower_sensor;
        logic center_sensor;
    } lflt_in_t;

    // One result per tick.
    typedef struct packed {
        logic [7:0] segments;
        logic       digit_select;
        logic       obstacle_alert;
        logic [1:0] drive_command;
        logic       race_finished;
        logic [6:0] elapsed_seconds;
    } lflt_out_t;

    typedef enum logic [1:0] {
        DRIVE_FORWARD = 2'd0,
        DRIVE_LEFT    = 2'd1,
        DRIVE_RIGHT   = 2'd2,
        DRIVE_STOP    = 2'd3
    } drive_t;

    localparam int unsigned TICK_W     = 16;
    localparam int unsigned SEC_W      = 7;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [TICK_W-1:0]     TICKS_RESET  = 16'd1000;
    localparam logic [SEC_W-1:0]      SECONDS_WRAP = 7'd100;
    localparam logic [CFG_ADDR_W-1:0] ADDR_TICKS   = 3'd0;

    // Active-low seven segment pattern of one decimal digit.
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        unique case (digit)
            4'd0:    code = 8'hc0;
            4'd1:    code = 8'hf9;
            4'd2:    code = 8'ha4;
            4'd3:    code = 8'hb0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hf8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = 8'hff;
        endcase
        return code;
    endfunction

    // Tens digit of a value below 100: multiply by 205 and drop eleven bits.
    function automatic logic [3:0] tens_of(input logic [SEC_W-1:0] value);
        logic [14:0] product;
        product = 15'(value) * 15'd205;
        return product[14:11];
    endfunction

endpackage

[design/lflt_cfg.sv]
module lflt_cfg
    import lflt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [TICK_W-1:0]     ticks_per_second
);

    logic [TICK_W-1:0] tps_reg;
    logic [TICK_W-1:0] tps_next;
    logic              hit;

    assign hit = (paddr == ADDR_TICKS);

    // Register write in the access phase.
    always_comb
    begin
        tps_next = tps_reg;
        if (psel && penable && pwrite && hit)
        begin
            tps_next = pwdata[TICK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= TICKS_RESET;
        end
        else
        begin
            tps_reg <= tps_next;
        end
    end

    // Read-back; unmapped addresses read as zero.
    assign prdata           = hit ? CFG_DATA_W'(tps_reg) : '0;
    assign pready           = 1'b1;
    assign ticks_per_second = tps_reg;

endmodule

[design/lflt_in_stage.sv]
module lflt_in_stage
    import lflt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     sensor_valid,
    output logic     sensor_ready,
    input  lflt_in_t sensors,
    output logic     held_valid,
    input  logic     held_take,
    output lflt_in_t held_sensors
);

    logic     valid_reg;
    logic     valid_next;
    lflt_in_t data_reg;

    // The stage takes a new request when empty or when its contents move on.
    assign sensor_ready = !valid_reg || held_take;

    always_comb
    begin
        valid_next = valid_reg;
        if (sensor_ready)
        begin
            valid_next = sensor_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sensor_ready && sensor_valid)
        begin
            data_reg <= sensors;
        end
    end

    assign held_valid   = valid_reg;
    assign held_sensors = data_reg;

endmodule

[design/lflt_core.sv]
module lflt_core
    import lflt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [TICK_W-1:0] ticks_per_second,
    input  logic              held_valid,
    output logic              held_take,
    input  lflt_in_t          held_sensors,
    output logic              result_valid,
    input  logic              result_ready,
    output lflt_out_t         result
);

    logic [TICK_W-1:0] tick_reg;
    logic [TICK_W-1:0] tick_next;
    logic [SEC_W-1:0]  sec_reg;
    logic [SEC_W-1:0]  sec_next;
    logic              finish_reg;
    logic              finish_next;
    logic              phase_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    lflt_out_t         out_reg;
    lflt_out_t         out_next;

    drive_t            drive;
    logic [TICK_W:0]   tick_inc;
    logic              second_done;
    logic [SEC_W-1:0]  sec_inc;
    logic [3:0]        tens;
    logic [SEC_W-1:0]  tens_x10;
    logic [3:0]        ones;
    logic [3:0]        digit;

    // A tick is processed when the result register is free or being emptied.
    assign held_take = held_valid && (!out_valid_reg || result_ready);

    // Steering and the sticky finish mark.
    always_comb
    begin
        finish_next = finish_reg
                   || (!held_sensors.center_sensor
                       && !held_sensors.right_lower_sensor
                       && !held_sensors.left_lower_sensor);
        priority if (finish_next)
        begin
            drive = DRIVE_STOP;
        end
        else if (held_sensors.center_sensor && held_sensors.right_lower_sensor)
        begin
            drive = DRIVE_LEFT;
        end
        else if (held_sensors.center_sensor && held_sensors.left_lower_sensor)
        begin
            drive = DRIVE_RIGHT;
        end
        else
        begin
            drive = DRIVE_FORWARD;
        end
    end

    // Tick counter and the two-digit seconds counter.
    always_comb
    begin
        tick_inc    = {1'b0, tick_reg} + 1'b1;
        second_done = (tick_inc >= {1'b0, ticks_per_second});
        tick_next   = second_done ? '0 : tick_inc[TICK_W-1:0];
        sec_inc     = sec_reg + 1'b1;
        sec_next    = sec_reg;
        if (second_done && !finish_next)
        begin
            sec_next = (sec_inc >= SECONDS_WRAP) ? '0 : sec_inc;
        end
    end

    // Digit of the updated count for this tick's display phase.
    always_comb
    begin
        tens     = tens_of(sec_next);
        tens_x10 = SEC_W'({tens, 3'b000}) + SEC_W'({tens, 1'b0});
        ones     = 4'(sec_next - tens_x10);
        digit    = phase_reg ? tens : ones;

        out_next.segments        = seg_code(digit);
        out_next.digit_select    = phase_reg;
        out_next.obstacle_alert  = !held_sensors.left_upper_sensor
                                || !held_sensors.right_upper_sensor;
        out_next.drive_command   = drive;
        out_next.race_finished   = finish_next;
        out_next.elapsed_seconds = sec_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (held_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // State and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            sec_reg       <= '0;
            finish_reg    <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (held_take)
            begin
                tick_reg   <= tick_next;
                sec_reg    <= sec_next;
                finish_reg <= finish_next;
                phase_reg  <= !phase_reg;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (held_take)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

[design/line_follower_lap_timer.sv]
// Line-follower lap timer.
// Each request on the sensors channel is one timer tick carrying the five
// sensor levels; each tick gives exactly one request on the result channel
// with the steering command, finish flag, obstacle alert, seconds count and
// the segment pattern of the digit shown on this tick.
// A request accepted into the input register is processed into the result
// register and presented on the result channel from then on until taken.
// One tick is taken per cycle while the receiver takes results; the rate
// is set by the single state update between the input register and the
// result register.
// When the receiver stalls, the result is held and a tick already in the
// input register waits there; sensor_ready stays low until the result is
// taken. An empty input register still takes one tick before it fills.
// The APB port holds ticks_per_second at address 0; the user must write it
// only while idle; the block does not enforce this. Reset clears the
// counters, the finish flag and the display phase (ones digit first) and sets
// ticks_per_second to 1000; there is no clearing pass, so ticks are accepted at once.
module line_follower_lap_timer
    import lflt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  sensor_valid,
    output logic                  sensor_ready,
    input  lflt_in_t              sensors,
    output logic                  result_valid,
    input  logic                  result_ready,
    output lflt_out_t             result
);

    logic [TICK_W-1:0] ticks_per_second;
    logic              held_valid;
    logic              held_take;
    lflt_in_t          held_sensors;

    lflt_cfg u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .ticks_per_second (ticks_per_second)
    );

    lflt_in_stage u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .sensor_valid (sensor_valid),
        .sensor_ready (sensor_ready),
        .sensors      (sensors),
        .held_valid   (held_valid),
        .held_take    (held_take),
        .held_sensors (held_sensors)
    );

    lflt_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .ticks_per_second (ticks_per_second),
        .held_valid       (held_valid),
        .held_take        (held_take),
        .held_sensors     (held_sensors),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .result           (result)
    );

endmodule
